// ===== hdl/wsld_pkg.sv =====
// Shared constants, types and controller/datapath bundles for the window stability lock detector.
package wsld_pkg;

    localparam int unsigned WINDOW_DEPTH    = 50;
    localparam int unsigned DATA_W          = 32;
    localparam int unsigned PTR_W           = $clog2(WINDOW_DEPTH);
    localparam int unsigned CNT_W           = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned AXES            = 3;
    localparam int unsigned RAM_W           = AXES * DATA_W;
    localparam logic [DATA_W-1:0] THRESHOLD_RESET = DATA_W'(16777);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic fill_zero;
        logic last_issue;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hdl/wsld_ifs.sv =====
// Valid/ready channel interfaces for the sample input and the lock result output.
interface wsld_in_if;
    logic                           valid;
    logic                           ready;
    logic [wsld_pkg::DATA_W-1:0]    var_x;
    logic [wsld_pkg::DATA_W-1:0]    var_y;
    logic [wsld_pkg::DATA_W-1:0]    var_z;
    logic                           beacon_available;
    logic                           sensors_calibrated;
    logic                           clear_window;

    modport source (
        output valid, var_x, var_y, var_z, beacon_available, sensors_calibrated, clear_window,
        input  ready
    );
    modport sink (
        input  valid, var_x, var_y, var_z, beacon_available, sensors_calibrated, clear_window,
        output ready
    );
endinterface

interface wsld_out_if;
    logic                           valid;
    logic                           ready;
    logic                           locked;
    logic                           window_full;
    logic [wsld_pkg::DATA_W-1:0]    spread_x;
    logic [wsld_pkg::DATA_W-1:0]    spread_y;
    logic [wsld_pkg::DATA_W-1:0]    spread_z;

    modport source (
        output valid, locked, window_full, spread_x, spread_y, spread_z,
        input  ready
    );
    modport sink (
        input  valid, locked, window_full, spread_x, spread_y, spread_z,
        output ready
    );
endinterface

// ===== hdl/window_stability_lock_detector_unit.sv =====
// Top level of the window stability lock detector: sequencer, datapath and checks.
//
// i_in carries one item: three unsigned Q8.24 variance samples (X, Y, Z), the
// beacon and calibration flags and a clear bit. A non-clear item is stored in
// a circular window of WINDOW_DEPTH entries; a clear item empties the window.
// o_out returns one result per item: the max-minus-min spread of each axis
// over the filled window, window_full, and locked (window full, every spread
// below spread_threshold, both flags set).
// i_cfg_we / i_cfg_wdata write spread_threshold; write it only while idle.
// After an item is accepted, the window RAM is read one entry per cycle
// and min/max are folded in as the words come back; a clear item skips
// the walk. i_in.ready is high only between items, so the next item is
// taken only once the result of the last one is loaded. The result sits
// in an output register, so the next item is taken while it waits; a
// stalled receiver holds the walk of the next item at its final step until
// o_out is free.
// Reset clears pointer, fill count and threshold (to 16777); the RAM contents
// need no clearing since only entries written since the last clear are read.
module window_stability_lock_detector_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    wsld_in_if.sink                      i_in,
    wsld_out_if.source                   o_out,
    input  logic                         i_cfg_we,
    input  logic [wsld_pkg::DATA_W-1:0]  i_cfg_wdata
);

    wsld_pkg::t_ctrl_cmd  s_cmd;
    wsld_pkg::t_dp_status s_status;

    wsld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (s_status),
        .o_cmd      (s_cmd)
    );

    wsld_datapath u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (s_cmd),
        .o_status             (s_status),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_var_x              (i_in.var_x),
        .i_var_y              (i_in.var_y),
        .i_var_z              (i_in.var_z),
        .i_beacon_available   (i_in.beacon_available),
        .i_sensors_calibrated (i_in.sensors_calibrated),
        .i_clear_window       (i_in.clear_window),
        .i_out_ready          (o_out.ready),
        .o_out_valid          (o_out.valid),
        .o_locked             (o_out.locked),
        .o_window_full        (o_out.window_full),
        .o_spread_x           (o_out.spread_x),
        .o_spread_y           (o_out.spread_y),
        .o_spread_z           (o_out.spread_z)
    );

    // one item in flight: no new item right after acceptance
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("item accepted while previous still in progress");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.load_out |-> s_status.out_free)
        else $error("result overwrote an untaken result");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.rd_issue |-> !s_status.fill_zero)
        else $error("window walk on empty window");

    a_lock_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.locked |-> o_out.window_full)
        else $error("lock reported with window not full");

endmodule

// ===== hdl/wsld_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wsld_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/wsld_ctrl.sv =====
// Sequencer: takes an item, walks the filled window, then hands the result to the output register.
module wsld_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  wsld_pkg::t_dp_status  i_status,
    output wsld_pkg::t_ctrl_cmd   o_cmd
);

    wsld_pkg::t_state r_state;
    wsld_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wsld_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            wsld_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = wsld_pkg::ST_CHECK;
                end
            end
            wsld_pkg::ST_CHECK: begin
                // fill count is updated by now; an empty window skips the walk
                if (i_status.fill_zero) begin
                    n_state = wsld_pkg::ST_DONE;
                end else begin
                    n_state = wsld_pkg::ST_SCAN;
                end
            end
            wsld_pkg::ST_SCAN: begin
                o_cmd.rd_issue = 1'b1;
                if (i_status.last_issue) begin
                    n_state = wsld_pkg::ST_DRAIN;
                end
            end
            wsld_pkg::ST_DRAIN: begin
                // last read word is folded into min/max here
                n_state = wsld_pkg::ST_DONE;
            end
            wsld_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = wsld_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wsld_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/wsld_datapath.sv =====
// Window storage, pointers, running min/max per axis, threshold register and output register.
module wsld_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wsld_pkg::t_ctrl_cmd           i_cmd,
    output wsld_pkg::t_dp_status          o_status,
    input  logic                          i_cfg_we,
    input  logic [wsld_pkg::DATA_W-1:0]   i_cfg_wdata,
    input  logic [wsld_pkg::DATA_W-1:0]   i_var_x,
    input  logic [wsld_pkg::DATA_W-1:0]   i_var_y,
    input  logic [wsld_pkg::DATA_W-1:0]   i_var_z,
    input  logic                          i_beacon_available,
    input  logic                          i_sensors_calibrated,
    input  logic                          i_clear_window,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_locked,
    output logic                          o_window_full,
    output logic [wsld_pkg::DATA_W-1:0]   o_spread_x,
    output logic [wsld_pkg::DATA_W-1:0]   o_spread_y,
    output logic [wsld_pkg::DATA_W-1:0]   o_spread_z
);

    localparam int unsigned DW = wsld_pkg::DATA_W;
    localparam int unsigned PW = wsld_pkg::PTR_W;
    localparam int unsigned CW = wsld_pkg::CNT_W;

    logic [DW-1:0]               r_thr;
    logic [PW-1:0]               r_wp;
    logic [CW-1:0]               r_fill;
    logic [PW-1:0]               r_idx;
    logic                        r_acc_vld;
    logic [DW-1:0]               r_hi [wsld_pkg::AXES];
    logic [DW-1:0]               r_lo [wsld_pkg::AXES];
    logic                        r_beacon;
    logic                        r_cal;
    logic                        r_out_valid;
    logic                        r_out_locked;
    logic                        r_out_full;
    logic [DW-1:0]               r_out_spread [wsld_pkg::AXES];

    logic [wsld_pkg::RAM_W-1:0]  s_rd_data;
    logic [DW-1:0]               s_word [wsld_pkg::AXES];
    logic [DW-1:0]               s_spread [wsld_pkg::AXES];
    logic                        s_full;
    logic                        s_under;
    logic                        s_wr_en;

    assign s_wr_en = i_cmd.accept && !i_clear_window;

    wsld_ram #(
        .WIDTH (wsld_pkg::RAM_W),
        .DEPTH (wsld_pkg::WINDOW_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s_wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data ({i_var_z, i_var_y, i_var_x}),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (r_idx),
        .o_rd_data (s_rd_data)
    );

    always_comb begin
        for (int a = 0; a < wsld_pkg::AXES; a++) begin
            s_word[a]   = s_rd_data[a*DW +: DW];
            s_spread[a] = (r_fill == '0) ? '0 : r_hi[a] - r_lo[a];
        end
    end

    assign s_full  = (r_fill == CW'(wsld_pkg::WINDOW_DEPTH));
    assign s_under = (s_spread[0] < r_thr) && (s_spread[1] < r_thr) && (s_spread[2] < r_thr);

    assign o_status.fill_zero  = (r_fill == '0);
    assign o_status.last_issue = ((CW'(r_idx) + CW'(1)) == r_fill);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= wsld_pkg::THRESHOLD_RESET;
            r_wp        <= '0;
            r_fill      <= '0;
            r_acc_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                if (i_clear_window) begin
                    r_wp   <= '0;
                    r_fill <= '0;
                end else begin
                    r_wp <= (r_wp == PW'(wsld_pkg::WINDOW_DEPTH - 1)) ? '0 : r_wp + PW'(1);
                    if (!s_full) begin
                        r_fill <= r_fill + CW'(1);
                    end
                end
            end
            r_acc_vld <= i_cmd.rd_issue;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx    <= '0;
            r_beacon <= i_beacon_available;
            r_cal    <= i_sensors_calibrated;
        end else if (i_cmd.rd_issue) begin
            r_idx <= r_idx + PW'(1);
        end
        for (int a = 0; a < wsld_pkg::AXES; a++) begin
            if (i_cmd.accept) begin
                r_hi[a] <= '0;
                r_lo[a] <= '1;
            end else if (r_acc_vld) begin
                if (s_word[a] > r_hi[a]) begin
                    r_hi[a] <= s_word[a];
                end
                if (s_word[a] < r_lo[a]) begin
                    r_lo[a] <= s_word[a];
                end
            end
        end
        if (i_cmd.load_out) begin
            r_out_locked <= s_full && s_under && r_beacon && r_cal;
            r_out_full   <= s_full;
            for (int a = 0; a < wsld_pkg::AXES; a++) begin
                r_out_spread[a] <= s_spread[a];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_locked      = r_out_locked;
    assign o_window_full = r_out_full;
    assign o_spread_x    = r_out_spread[0];
    assign o_spread_y    = r_out_spread[1];
    assign o_spread_z    = r_out_spread[2];

endmodule

// ===== test/wsld_lock_checker.sv =====
// Lock result checker: watches the sample and result channels, predicts each result, compares.
module wsld_lock_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    wsld_in_if                          i_in,
    wsld_out_if                         i_res,
    input  logic                        i_cfg_we,
    input  logic [wsld_pkg::DATA_W-1:0] i_cfg_wdata,
    output int unsigned                 o_mismatches,
    output int unsigned                 o_due,
    output int unsigned                 o_locks
);
    timeunit 1ns;
    timeprecision 1ps;
    import wsld_pkg::*;

    typedef struct packed {
        logic              locked;
        logic              window_full;
        logic [DATA_W-1:0] spread_x;
        logic [DATA_W-1:0] spread_y;
        logic [DATA_W-1:0] spread_z;
    } t_lock_result;

    logic [DATA_W-1:0] hist [AXES][WINDOW_DEPTH];
    int unsigned       wr_ptr = 0;
    int unsigned       fill = 0;
    logic [DATA_W-1:0] threshold = THRESHOLD_RESET;
    t_lock_result      lock_results_due [$];
    int unsigned       mismatch_count = 0;
    int unsigned       due_count = 0;
    int unsigned       lock_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_due        = due_count;
    assign o_locks      = lock_count;

    // max minus min over the filled part; after a clear the fill starts at entry 0
    function automatic logic [DATA_W-1:0] axis_spread(input int unsigned axis);
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] lo;
        hi = '0;
        lo = '1;
        if (fill == 0) begin
            return '0;
        end
        for (int unsigned i = 0; i < fill; i++) begin
            if (hist[axis][i] > hi) begin
                hi = hist[axis][i];
            end
            if (hist[axis][i] < lo) begin
                lo = hist[axis][i];
            end
        end
        return hi - lo;
    endfunction

    task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_lock_result want;
        t_lock_result got;
        if (!i_rst_n) begin
            threshold = THRESHOLD_RESET;
            wr_ptr    = 0;
            fill      = 0;
            lock_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                threshold = i_cfg_wdata;
            end
            if (i_res.valid && i_res.ready) begin
                got.locked      = i_res.locked;
                got.window_full = i_res.window_full;
                got.spread_x    = i_res.spread_x;
                got.spread_y    = i_res.spread_y;
                got.spread_z    = i_res.spread_z;
                if (got.locked === 1'b1) begin
                    lock_count++;
                end
                if (lock_results_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with no item pending, expected none, actual %p",
                             $time, got);
                end else begin
                    want = lock_results_due.pop_front();
                    check_field("locked", DATA_W'(want.locked), DATA_W'(got.locked));
                    check_field("window_full", DATA_W'(want.window_full),
                                DATA_W'(got.window_full));
                    check_field("spread_x", want.spread_x, got.spread_x);
                    check_field("spread_y", want.spread_y, got.spread_y);
                    check_field("spread_z", want.spread_z, got.spread_z);
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.clear_window) begin
                    wr_ptr = 0;
                    fill   = 0;
                end else begin
                    hist[0][wr_ptr] = i_in.var_x;
                    hist[1][wr_ptr] = i_in.var_y;
                    hist[2][wr_ptr] = i_in.var_z;
                    wr_ptr = (wr_ptr == WINDOW_DEPTH - 1) ? 0 : wr_ptr + 1;
                    if (fill < WINDOW_DEPTH) begin
                        fill++;
                    end
                end
                want.spread_x    = axis_spread(0);
                want.spread_y    = axis_spread(1);
                want.spread_z    = axis_spread(2);
                want.window_full = (fill == WINDOW_DEPTH);
                want.locked      = want.window_full && (want.spread_x < threshold) &&
                                   (want.spread_y < threshold) && (want.spread_z < threshold) &&
                                   i_in.beacon_available && i_in.sensors_calibrated;
                lock_results_due.push_back(want);
            end
        end
        due_count = lock_results_due.size();
    end

endmodule

// ===== test/tb_window_stability_lock_detector_unit.sv =====
// Testbench top for the window stability lock detector: stimulus, handshake pacing and verdict.
module tb_window_stability_lock_detector_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import wsld_pkg::*;

    localparam int unsigned RESET_CYCLES   = 11;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES    = 80;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned PHASES         = 5;
    localparam int unsigned PHASE_ITEMS    = 185;

    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
        logic              beacon;
        logic              calib;
        logic              clr;
    } t_sample;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [DATA_W-1:0] cfg_wdata = '0;

    wsld_in_if  in_ch ();
    wsld_out_if res_ch ();

    int unsigned chk_mismatches;
    int unsigned chk_due;
    int unsigned chk_locks;
    int unsigned items_sent = 0;
    int unsigned clears_sent = 0;
    int unsigned thresholds_written = 0;
    int unsigned idle_cycles = 0;
    bit          src_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;
    bit          hold_req = 1'b0;

    window_stability_lock_detector_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    wsld_lock_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (chk_mismatches),
        .o_due        (chk_due),
        .o_locks      (chk_locks)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("window_stability_lock_detector_unit regression: fail");
                $finish;
            end
        end
    end

    // result receiver: random stall bursts, plus one long hold on request
    initial begin : result_sink
        res_ch.ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    function automatic t_sample sample_of(input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
                                          input logic [DATA_W-1:0] z, input logic beacon,
                                          input logic calib, input logic clr);
        t_sample s;
        s.x      = x;
        s.y      = y;
        s.z      = z;
        s.beacon = beacon;
        s.calib  = calib;
        s.clr    = clr;
        return s;
    endfunction

    function automatic logic [DATA_W-1:0] rough_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] threshold_for_phase(input int unsigned ph);
        case (ph)
            1:       return '0;
            2:       return '1;
            3:       return DATA_W'(20000);
            default: return DATA_W'(1 << 20);
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_sample(input t_sample s);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        in_ch.valid              <= 1'b1;
        in_ch.var_x              <= s.x;
        in_ch.var_y              <= s.y;
        in_ch.var_z              <= s.z;
        in_ch.beacon_available   <= s.beacon;
        in_ch.sensors_calibrated <= s.calib;
        in_ch.clear_window       <= s.clr;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        items_sent++;
        if (s.clr) begin
            clears_sent++;
        end
    endtask

    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (chk_due != 0);
    endtask

    task automatic write_threshold(input logic [DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
        thresholds_written++;
    endtask

    // mostly a clear followed by a run of clustered samples, so the window fills and locks
    task automatic run_sequence(input int unsigned len);
        t_sample           s;
        logic [DATA_W-1:0] span;
        logic [DATA_W-1:0] bx;
        logic [DATA_W-1:0] by;
        logic [DATA_W-1:0] bz;
        bit                steady;
        steady = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 4))
            0:       span = '0;
            1:       span = DATA_W'(255);
            2:       span = DATA_W'(16000);
            3:       span = DATA_W'(17500);
            default: span = DATA_W'(1048000);
        endcase
        bx = $urandom_range(0, 32'hFFFF_FFFF - span);
        by = $urandom_range(0, 32'hFFFF_FFFF - span);
        bz = $urandom_range(0, 32'hFFFF_FFFF - span);
        if ($urandom_range(0, 3) != 0) begin
            send_sample(sample_of(rough_value(), rough_value(), rough_value(),
                                  1'($urandom), 1'($urandom), 1'b1));
        end
        for (int unsigned i = 0; i < len; i++) begin
            if (steady) begin
                s.x = bx + $urandom_range(0, span);
                s.y = by + $urandom_range(0, span);
                s.z = bz + $urandom_range(0, span);
            end else begin
                s.x = rough_value();
                s.y = rough_value();
                s.z = rough_value();
            end
            s.beacon = ($urandom_range(0, 7) != 0);
            s.calib  = ($urandom_range(0, 7) != 0);
            s.clr    = ($urandom_range(0, 149) == 0);
            send_sample(s);
        end
    endtask

    initial begin : stimulus
        int unsigned phase_end;
        int unsigned seq_len;
        in_ch.valid              = 1'b0;
        in_ch.var_x              = '0;
        in_ch.var_y              = '0;
        in_ch.var_z              = '0;
        in_ch.beacon_available   = 1'b0;
        in_ch.sensors_calibrated = 1'b0;
        in_ch.clear_window       = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed items at the reset threshold
        send_sample(sample_of('1, '1, '1, 1'b1, 1'b1, 1'b1));
        send_sample(sample_of('0, '0, '0, 1'b0, 1'b0, 1'b0));
        send_sample(sample_of('1, '1, '1, 1'b1, 1'b0, 1'b0));
        send_sample(sample_of(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 1'b1, 1'b0));
        send_sample(sample_of(32'h5555_5555, '0, '1, 1'b1, 1'b1, 1'b0));
        send_sample(sample_of(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b1));
        // equal samples into a partly filled window: zero spread, never locked
        repeat (8) send_sample(sample_of(32'h0100_0000, 32'h0000_4189, 32'hFFFF_FFFE,
                                         1'b1, 1'b1, 1'b0));
        send_sample(sample_of('0, '1, '0, 1'b1, 1'b1, 1'b0));
        send_sample(sample_of('0, '0, '0, 1'b0, 1'b0, 1'b1));

        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                wait_results_drained();
                repeat (SETTLE_CYCLES) @(negedge i_clk);
                write_threshold(threshold_for_phase(ph));
            end
            if (ph == PHASES - 1) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            phase_end = items_sent + PHASE_ITEMS;
            if (ph == 1) begin
                // receiver holds off while the sender keeps offering back to back
                hold_req    = 1'b1;
                src_idle_on = 1'b0;
                run_sequence(12);
                src_idle_on = 1'b1;
            end
            if (ph == 2) begin
                run_sequence(60);
                wait_results_drained();
            end
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 3) == 0) begin
                    seq_len = $urandom_range(1, 49);
                end else begin
                    seq_len = $urandom_range(50, 130);
                end
                // keep the phase close to its item budget
                if (seq_len > phase_end - items_sent) begin
                    seq_len = phase_end - items_sent;
                end
                run_sequence(seq_len);
            end
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("run covered %0d items, %0d of them window clears, %0d threshold writes",
                 items_sent, clears_sent, thresholds_written);
        $display("%0d results reported lock; long output stall and full drain both exercised",
                 chk_locks);
        if (chk_mismatches == 0 && chk_due == 0) begin
            $display("window_stability_lock_detector_unit regression: pass");
        end else begin
            $display("window_stability_lock_detector_unit regression: fail");
        end
        $finish;
    end

endmodule
